// ----- hdl/lph_pkg.sv -----
package lph_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;

  localparam int MAX_SLOTS_LOG2 = 10;
  localparam int MIN_SLOTS      = 16;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_GOT       = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_UPDATED   = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] KNUTH_MUL = 32'd2654435761;

  localparam logic REG_CAP  = 1'b0;
  localparam logic REG_HASH = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] rdata;
    logic [9:0]  slot_index;
    logic [10:0] entry_count;
  } lph_result_t;

endpackage

// ----- hdl/lph_hash.sv -----
// Multi-cycle hash: Knuth takes one multiply, FNV-1a one byte per cycle.
module lph_hash import lph_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        mode,
  input  logic [31:0] key,
  output logic        done,
  output logic [31:0] hash
);

  logic [31:0] h_r, h_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        mode_r;
  logic [31:0] key_r;
  logic [7:0]  byte_sel;

  always_comb begin
    byte_sel = key_r[8*cnt_r[1:0] +: 8];
    h_nxt    = h_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      h_nxt    = FNV_BASIS;
    end else if (busy_r) begin
      if (!mode_r) begin
        h_nxt    = key_r * KNUTH_MUL;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        h_nxt   = (h_r ^ {24'd0, byte_sel}) * FNV_PRIME;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r <= h_nxt;
    if (start) begin
      key_r  <= key;
      mode_r <= mode;
    end
  end

  assign done = done_r;
  assign hash = h_r;

endmodule

// ----- hdl/lph_store.sv -----
// Slot memories. Status sits in its own RAM so clear can sweep it.
module lph_store import lph_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_status,
  output logic [31:0]   rd_hash,
  output logic [31:0]   rd_key,
  output logic [31:0]   rd_value,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_status_en,
  input  logic [1:0]    wr_status,
  input  logic          wr_entry_en,
  input  logic [31:0]   wr_hash,
  input  logic [31:0]   wr_key,
  input  logic          wr_value_en,
  input  logic [31:0]   wr_value
);

  localparam int DEPTH = 1 << AW;

  logic [1:0]  status_mem [DEPTH];
  logic [63:0] entry_mem  [DEPTH];
  logic [31:0] value_mem  [DEPTH];
  logic [63:0] entry_q;

  always_ff @(posedge clk) begin
    if (wr_status_en) status_mem[wr_addr] <= wr_status;
    rd_status <= status_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_entry_en) entry_mem[wr_addr] <= {wr_hash, wr_key};
    entry_q <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_value_en) value_mem[wr_addr] <= wr_value;
    rd_value <= value_mem[rd_addr];
  end

  assign rd_hash = entry_q[63:32];
  assign rd_key  = entry_q[31:0];

endmodule

// ----- hdl/linear_probe_hash_table_core.sv -----
// Open-addressing key/value table with linear probing.
// Input channel (in_valid/in_ready) carries opcode, key and value; the result
// channel (out_valid/out_ready) returns status, hit, rdata, slot_index and
// entry_count, one result per item, in order. cfg_* is an APB-style port:
// register 0 capacity_log2 at 0x0, register 1 hash_mode at 0x4.
// Sequence: a put, get or remove is first hashed (Knuth or FNV-1a), then
// each probed slot passes through S_READ, where the synchronous slot RAM
// is read, and S_CHECK, which also writes back on the last probed slot.
// Items are taken one at a time, only in S_IDLE. Clear sweeps the status
// RAM, one slot per cycle, over all 2**MAX_SLOTS_LOG2 slots.
// Reset runs the same sweep over every slot with in_ready low;
// configuration writes are taken throughout. The result sits in an output
// register; while the receiver stalls it holds, and the next item is taken
// and processed up to its result, which then waits.
module linear_probe_hash_table_core import lph_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_hit,
  output logic [31:0] out_rdata,
  output logic [9:0]  out_slot_index,
  output logic [10:0] out_entry_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = MAX_SLOTS_LOG2;
  localparam int CW = AW + 1;
  localparam int MIN_LOG2 = $clog2(MIN_SLOTS);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_HASH, S_READ, S_CHECK, S_DONE, S_HOLD
  } state_t;

  state_t        state_r;
  logic [3:0]    cap_log2_r;
  logic          hash_mode_r;
  logic [1:0]    op_r;
  logic [31:0]   key_r, val_r, h_r;
  logic [AW-1:0] idx_r, tomb_r, sweep_r;
  logic          have_tomb_r;
  logic [CW-1:0] steps_r, cap_c;
  logic [CW-1:0] occ_r, tombs_r;
  logic [AW-1:0] mask_c;
  logic [3:0]    lg_c;
  lph_result_t   res_r;
  logic          res_valid_r;
  logic          pend_r;
  lph_result_t   pend_q_r;
  logic          pend_move;

  logic          hash_start, hash_done;
  logic [31:0]   hash_val;
  logic [1:0]    rd_status;
  logic [31:0]   rd_hash, rd_key, rd_value;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_status_en, wr_entry_en, wr_value_en;
  logic [1:0]    wr_status;
  logic          cfg_wr;

  // effective capacity mask
  always_comb begin
    lg_c = cap_log2_r;
    if (lg_c > 4'(MAX_SLOTS_LOG2)) lg_c = 4'(MAX_SLOTS_LOG2);
    if (lg_c < 4'(MIN_LOG2)) lg_c = 4'(MIN_LOG2);
    cap_c  = CW'(1) << lg_c;
    mask_c = AW'(cap_c - CW'(1));
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == REG_CAP) cfg_prdata = {28'd0, cap_log2_r};
    else cfg_prdata = {31'd0, hash_mode_r};
  end

  assign in_ready   = (state_r == S_IDLE);
  assign hash_start = in_valid && in_ready && (in_opcode != OP_CLEAR);
  assign out_valid  = res_valid_r;
  assign pend_move  = pend_r && (!res_valid_r || out_ready);

  lph_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .mode(hash_mode_r),
    .key(in_key), .done(hash_done), .hash(hash_val)
  );

  assign rd_addr = idx_r;

  lph_store #(.AW(AW)) u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_status(rd_status), .rd_hash(rd_hash),
    .rd_key(rd_key), .rd_value(rd_value), .wr_addr(wr_addr),
    .wr_status_en(wr_status_en), .wr_status(wr_status),
    .wr_entry_en(wr_entry_en), .wr_hash(h_r), .wr_key(key_r),
    .wr_value_en(wr_value_en), .wr_value(val_r)
  );

  // probe decision on the slot just read
  logic          is_hit, stop, exhausted, ins_ok;
  logic [AW-1:0] ins_slot;
  always_comb begin
    is_hit    = (rd_status == SLOT_USED) && (rd_hash == h_r) && (rd_key == key_r);
    exhausted = (steps_r + CW'(1) == cap_c);
    stop      = is_hit || (rd_status == SLOT_EMPTY) || exhausted;
    ins_ok    = have_tomb_r || (rd_status == SLOT_EMPTY) || (rd_status == SLOT_TOMB);
    ins_slot  = have_tomb_r ? tomb_r : idx_r;
  end

  // write port
  always_comb begin
    wr_addr      = idx_r;
    wr_status_en = 1'b0;
    wr_status    = SLOT_EMPTY;
    wr_entry_en  = 1'b0;
    wr_value_en  = 1'b0;
    if (state_r == S_INIT) begin
      wr_addr      = sweep_r;
      wr_status_en = 1'b1;
    end else if (state_r == S_CHECK && stop) begin
      if (is_hit) begin
        if (op_r == OP_PUT) wr_value_en = 1'b1;
        else if (op_r == OP_REMOVE) begin
          wr_status_en = 1'b1;
          wr_status    = SLOT_TOMB;
        end
      end else if (op_r == OP_PUT && ins_ok) begin
        wr_addr      = ins_slot;
        wr_status_en = 1'b1;
        wr_status    = SLOT_USED;
        wr_entry_en  = 1'b1;
        wr_value_en  = 1'b1;
      end
    end
  end

  lph_result_t   res_nxt;
  logic [CW-1:0] occ_nxt, tombs_nxt;
  always_comb begin
    res_nxt   = '0;
    occ_nxt   = occ_r;
    tombs_nxt = tombs_r;
    if (is_hit) begin
      res_nxt.hit        = 1'b1;
      res_nxt.slot_index = SLOT_W'(idx_r);
      unique case (op_r)
        OP_PUT: res_nxt.status = ST_UPDATED;
        OP_GET: begin
          res_nxt.status = ST_GOT;
          res_nxt.rdata  = rd_value;
        end
        default: begin
          res_nxt.status = ST_REMOVED;
          if (occ_r != '0) occ_nxt = occ_r - CW'(1);
          tombs_nxt = tombs_r + CW'(1);
        end
      endcase
    end else if (op_r != OP_PUT) begin
      res_nxt.status = ST_NOT_FOUND;
    end else if (!ins_ok) begin
      res_nxt.status = ST_FULL;
    end else begin
      res_nxt.status     = ST_INSERTED;
      res_nxt.slot_index = SLOT_W'(ins_slot);
      occ_nxt            = occ_r + CW'(1);
      if ((have_tomb_r || rd_status == SLOT_TOMB) && tombs_r != '0)
        tombs_nxt = tombs_r - CW'(1);
    end
    res_nxt.entry_count = COUNT_W'(occ_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      cap_log2_r  <= 4'd4;
      hash_mode_r <= 1'b0;
      occ_r       <= '0;
      tombs_r     <= '0;
      res_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_CAP)  cap_log2_r  <= cfg_pwdata[3:0];
      if (cfg_wr && cfg_paddr[2] == REG_HASH) hash_mode_r <= cfg_pwdata[0];
      // move a pending result into the output register
      if (pend_move) begin
        res_r       <= pend_q_r;
        res_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (res_valid_r && out_ready) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          sweep_r <= sweep_r + AW'(1);
          if (sweep_r == '1) state_r <= pend_r ? S_HOLD : S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_opcode;
            key_r <= in_key;
            val_r <= in_value;
            if (in_opcode == OP_CLEAR) begin
              occ_r    <= '0;
              tombs_r  <= '0;
              sweep_r  <= '0;
              pend_q_r <= '{status: ST_CLEARED, default: '0};
              pend_r   <= 1'b1;
              state_r  <= S_INIT;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            h_r         <= hash_val;
            idx_r       <= AW'(hash_val) & mask_c;
            have_tomb_r <= 1'b0;
            steps_r     <= '0;
            state_r     <= S_READ;
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          if (stop) begin
            occ_r    <= occ_nxt;
            tombs_r  <= tombs_nxt;
            pend_q_r <= res_nxt;
            pend_r   <= 1'b1;
            state_r  <= S_HOLD;
          end else begin
            if (rd_status == SLOT_TOMB && !have_tomb_r) begin
              have_tomb_r <= 1'b1;
              tomb_r      <= idx_r;
            end
            idx_r   <= (idx_r + AW'(1)) & mask_c;
            steps_r <= steps_r + CW'(1);
            state_r <= S_READ;
          end
        end
        S_DONE: state_r <= S_IDLE;
        S_HOLD: begin
          // wait until the result has left the pending slot
          if (!pend_r || !res_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_status      = res_r.status;
  assign out_hit         = res_r.hit;
  assign out_rdata       = res_r.rdata;
  assign out_slot_index  = res_r.slot_index;
  assign out_entry_count = res_r.entry_count;

endmodule

// ----- hdl/lph_checker.sv -----
module lph_checker import lph_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_hit,
  input logic [31:0] out_rdata,
  input logic [9:0]  out_slot_index,
  input logic [10:0] out_entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed under stall");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CLEARED |-> out_entry_count == 11'd0 && !out_hit)
    else $error("clear result not zero");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_GOT || out_status == ST_UPDATED ||
                             out_status == ST_REMOVED)
    else $error("hit with wrong status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |-> out_rdata == 32'd0 &&
                                               out_slot_index == 10'd0)
    else $error("miss carries data");

endmodule

bind linear_probe_hash_table_core lph_checker u_lph_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_hit(out_hit), .out_rdata(out_rdata),
  .out_slot_index(out_slot_index), .out_entry_count(out_entry_count)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb import lph_pkg::*; ();

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
  } table_op_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic        out_hit;
  logic [31:0] out_rdata;
  logic [9:0]  out_slot_index;
  logic [10:0] out_entry_count;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  linear_probe_hash_table_core dut (.*);

  // table shadow
  logic [1:0]  sh_status [1024];
  logic [31:0] sh_hash   [1024];
  logic [31:0] sh_key    [1024];
  logic [31:0] sh_value  [1024];
  int unsigned sh_occupied;
  int unsigned sh_tombs;
  logic [3:0]  sh_cap_log2;
  logic        sh_fnv;

  table_op_t     pending_ops[$];
  lph_result_t   expected_results[$];
  table_op_t     cur_op;
  int            send_gap;
  int            recv_gap;
  int            mismatches;
  int            idle_cycles;
  bit            send_busy;
  bit            hold_stall;
  logic          in_taken;
  logic          out_taken;

  // keys already put, reused to hit the table
  logic [31:0]   known_keys[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned table_slots();
    int unsigned lg;
    lg = (sh_cap_log2 > 10) ? 10 : sh_cap_log2;
    return (lg < 4) ? 16 : (1 << lg);
  endfunction

  function automatic logic [31:0] hash_of(logic [31:0] key);
    logic [31:0] h;
    if (sh_fnv) begin
      h = FNV_BASIS;
      for (int b = 0; b < 4; b++) begin
        h = h ^ {24'd0, key[8*b +: 8]};
        h = h * FNV_PRIME;
      end
      return h;
    end
    return key * KNUTH_MUL;
  endfunction

  function automatic lph_result_t apply_op(table_op_t op);
    lph_result_t r;
    logic [31:0] h;
    int unsigned cap, start, idx, tomb, found;
    bit have_tomb, hit, ok, done;
    r = '0;
    if (op.opcode == OP_CLEAR) begin
      for (int i = 0; i < 1024; i++) sh_status[i] = SLOT_EMPTY;
      sh_occupied = 0;
      sh_tombs = 0;
      r.status = ST_CLEARED;
      return r;
    end
    h = hash_of(op.key);
    cap = table_slots();
    start = h % cap;
    have_tomb = 0; tomb = 0; hit = 0; ok = 1; done = 0; found = 0;
    for (int i = 0; i < cap && !done; i++) begin
      idx = (start + i) % cap;
      if (sh_status[idx] == SLOT_EMPTY) begin
        found = have_tomb ? tomb : idx;
        done = 1;
      end else if (sh_status[idx] != SLOT_USED) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb = idx;
        end
      end else if (sh_hash[idx] == h && sh_key[idx] == op.key) begin
        hit = 1;
        found = idx;
        done = 1;
      end
    end
    if (!done) begin
      if (have_tomb) found = tomb;
      else ok = 0;
    end
    r.hit = hit;
    if (op.opcode == OP_PUT) begin
      if (hit) begin
        sh_value[found] = op.value;
        r.slot_index = 10'(found);
        r.status = ST_UPDATED;
      end else if (!ok) begin
        r.status = ST_FULL;
      end else begin
        if (sh_status[found] == SLOT_TOMB && sh_tombs > 0) sh_tombs--;
        sh_status[found] = SLOT_USED;
        sh_hash[found] = h;
        sh_key[found] = op.key;
        sh_value[found] = op.value;
        sh_occupied++;
        r.slot_index = 10'(found);
        r.status = ST_INSERTED;
      end
    end else if (!hit) begin
      r.status = ST_NOT_FOUND;
    end else if (op.opcode == OP_GET) begin
      r.rdata = sh_value[found];
      r.slot_index = 10'(found);
      r.status = ST_GOT;
    end else begin
      sh_status[found] = SLOT_TOMB;
      if (sh_occupied > 0) sh_occupied--;
      sh_tombs++;
      r.slot_index = 10'(found);
      r.status = ST_REMOVED;
    end
    r.entry_count = sh_occupied[10:0];
    return r;
  endfunction

  // transfers seen at the rising edge, used by the falling-edge drivers
  always @(posedge clk) begin
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) send_busy = 0;
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          in_opcode <= cur_op.opcode;
          in_key <= cur_op.key;
          in_value <= cur_op.value;
          in_valid <= 1'b1;
          send_busy = 1;
          send_gap = $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_stall) begin
      out_ready <= 1'b1;
    end else begin
      if (out_taken) recv_gap = $urandom_range(0, 5);
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_op({in_opcode, in_key, in_value}));
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status=%0d", out_status);
        end else begin
          lph_result_t e;
          e = expected_results.pop_front();
          if (out_status !== e.status || out_hit !== e.hit ||
              out_rdata !== e.rdata || out_slot_index !== e.slot_index ||
              out_entry_count !== e.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d hit=%0d val=%h slot=%0d cnt=%0d got st=%0d hit=%0d val=%h slot=%0d cnt=%0d",
                       e.status, e.hit, e.rdata, e.slot_index, e.entry_count,
                       out_status, out_hit, out_rdata, out_slot_index,
                       out_entry_count);
          end
        end
      end
      if (idle_cycles >= 20000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic reg_idx, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == REG_CAP) sh_cap_log2 = data[3:0];
    else sh_fnv = data[0];
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || send_busy || expected_results.size() > 0)
      @(posedge clk);
    // clear sweep may still be running
    repeat (1100) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (known_keys.size() > 0 && sel < 6)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (sel < 8) return $urandom_range(0, 63);
    return $urandom;
  endfunction

  task automatic queue_op(logic [1:0] opc, logic [31:0] key, logic [31:0] val);
    pending_ops.push_back({opc, key, val});
    if (opc == OP_PUT) known_keys.push_back(key);
  endtask

  task automatic queue_random(int count, int put_weight);
    int r;
    logic [1:0] opc;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < put_weight) opc = OP_PUT;
      else if (r < put_weight + (99 - put_weight) / 2) opc = OP_GET;
      else if (r < 99) opc = OP_REMOVE;
      else opc = OP_CLEAR;
      queue_op(opc, pick_key(), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_PUT;
    in_key = '0;
    in_value = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    send_busy = 0;
    hold_stall = 0;
    sh_occupied = 0;
    sh_tombs = 0;
    sh_cap_log2 = 4;
    sh_fnv = 0;
    for (int i = 0; i < 1024; i++) sh_status[i] = SLOT_EMPTY;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, all ops, update, miss, tombstone reuse, full table
    queue_op(OP_GET, 32'h0, 32'h0);
    queue_op(OP_PUT, 32'h0, 32'hFFFF_FFFF);
    queue_op(OP_PUT, 32'hFFFF_FFFF, 32'h0);
    queue_op(OP_GET, 32'hFFFF_FFFF, 32'h0);
    queue_op(OP_PUT, 32'h0, 32'hA5A5_5A5A);
    queue_op(OP_GET, 32'h0, 32'h1234_5678);
    queue_op(OP_REMOVE, 32'h0, 32'h0);
    queue_op(OP_REMOVE, 32'h0, 32'h0);
    queue_op(OP_PUT, 32'h0, 32'h5555_AAAA);
    for (int k = 1; k <= 16; k++) queue_op(OP_PUT, 32'(k * 7), 32'(k));
    queue_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    cfg_write(REG_HASH, 32'd1);
    cfg_write(REG_CAP, 32'd15);
    queue_random(150, 45);
    wait_drained();

    // hash change with entries present
    cfg_write(REG_HASH, 32'd0);
    cfg_write(REG_CAP, 32'd4);
    queue_random(150, 50);
    wait_drained();

    cfg_write(REG_CAP, 32'd2);
    queue_random(120, 60);
    wait_drained();

    cfg_write(REG_CAP, 32'd10);
    cfg_write(REG_HASH, 32'd1);
    queue_random(150, 45);
    wait_drained();

    cfg_write(REG_CAP, 32'd6);
    queue_random(130, 40);
    wait_drained();

    cfg_write(REG_HASH, 32'd0);
    cfg_write(REG_CAP, 32'd5);
    hold_stall = 1;
    queue_random(125, 45);
    hold_stall = 0;
    wait_drained();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
